/* src/rvb_pkg.sv */
package rvb_pkg;

    // Delay store geometry (depth must be a power of two)
    localparam int DELAY_DEPTH = 8192;
    localparam int SAMPLE_BITS = 16;
    localparam int ADDR_W      = $clog2(DELAY_DEPTH);
    localparam int COUNT_W     = ADDR_W + 1;
    localparam int COUNT_MAX   = 2 * DELAY_DEPTH - 1;

    // Register field widths
    localparam int DELAY_W    = 13;
    localparam int GAIN_W     = 16;
    localparam int NUM_TAPS   = 4;
    localparam int TAP_IDX_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Datapath widths
    localparam int A_W    = GAIN_W + 1;
    localparam int TSUM_W = SAMPLE_BITS + 17;
    localparam int B_W    = SAMPLE_BITS + 18;
    localparam int P_W    = A_W + B_W;
    localparam int Y_W    = SAMPLE_BITS + 3;

    localparam logic signed [P_W-1:0] RND_W = P_W'(1) << (GAIN_W - 1);
    localparam logic signed [P_W-1:0] RND_Y = P_W'(1) << (2 * GAIN_W - 1);

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [Y_W-1:0] SAT_HI = {{(Y_W-SAMPLE_BITS){1'b0}}, SAMPLE_MAX};
    localparam logic signed [Y_W-1:0] SAT_LO = {{(Y_W-SAMPLE_BITS){1'b1}}, SAMPLE_MIN};

    // Tap decays, Q0.16
    localparam logic [GAIN_W-1:0] DECAY_FIRST  = 16'd39322;
    localparam logic [GAIN_W-1:0] DECAY_SECOND = 16'd32768;
    localparam logic [GAIN_W-1:0] DECAY_THIRD  = 16'd26214;
    localparam logic [GAIN_W-1:0] DECAY_FOURTH = 16'd19661;

    // Tap indexes
    localparam logic [TAP_IDX_W-1:0] TAP_FIRST  = 2'd0;
    localparam logic [TAP_IDX_W-1:0] TAP_SECOND = 2'd1;
    localparam logic [TAP_IDX_W-1:0] TAP_THIRD  = 2'd2;
    localparam logic [TAP_IDX_W-1:0] TAP_FOURTH = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_THIRD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_FOURTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WET_GAIN   = 3'd4;

    // Register reset values
    localparam logic [DELAY_W-1:0] RST_TAP_FIRST  = 13'd1014;
    localparam logic [DELAY_W-1:0] RST_TAP_SECOND = 13'd1631;
    localparam logic [DELAY_W-1:0] RST_TAP_THIRD  = 13'd2337;
    localparam logic [DELAY_W-1:0] RST_TAP_FOURTH = 13'd3483;
    localparam logic [GAIN_W-1:0]  RST_WET_GAIN   = 16'd19661;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        logic [NUM_TAPS-1:0][DELAY_W-1:0] tap_delay;
        logic [GAIN_W-1:0]                wet_gain;
    } t_cfg;

    typedef struct packed {
        logic                 accept;
        logic                 rd_en;
        logic [TAP_IDX_W-1:0] rd_tap;
        logic                 mac_en;
        logic                 mul_w;
        logic                 sum_v;
        logic                 mul_v;
        logic                 load_out;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_stat;

    function automatic logic [GAIN_W-1:0] decay_q16(input logic [TAP_IDX_W-1:0] k);
        logic [GAIN_W-1:0] d;
        case (k)
            TAP_FIRST:  d = DECAY_FIRST;
            TAP_SECOND: d = DECAY_SECOND;
            TAP_THIRD:  d = DECAY_THIRD;
            default:    d = DECAY_FOURTH;
        endcase
        return d;
    endfunction

endpackage

/* src/rvb_ctrl.sv */
module rvb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output rvb_pkg::t_cmd  o_cmd,
    input  rvb_pkg::t_stat i_stat
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD0  = 4'd1;
    localparam logic [3:0] S_RD1  = 4'd2;
    localparam logic [3:0] S_RD2  = 4'd3;
    localparam logic [3:0] S_RD3  = 4'd4;
    localparam logic [3:0] S_MAC3 = 4'd5;
    localparam logic [3:0] S_MULW = 4'd6;
    localparam logic [3:0] S_SUMV = 4'd7;
    localparam logic [3:0] S_MULV = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_RD0;
                end
            end
            S_RD0: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_tap = rvb_pkg::TAP_FIRST;
                n_state      = S_RD1;
            end
            S_RD1: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_tap = rvb_pkg::TAP_SECOND;
                o_cmd.mac_en = 1'b1;
                n_state      = S_RD2;
            end
            S_RD2: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_tap = rvb_pkg::TAP_THIRD;
                o_cmd.mac_en = 1'b1;
                n_state      = S_RD3;
            end
            S_RD3: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_tap = rvb_pkg::TAP_FOURTH;
                o_cmd.mac_en = 1'b1;
                n_state      = S_MAC3;
            end
            S_MAC3: begin
                o_cmd.mac_en = 1'b1;
                n_state      = S_MULW;
            end
            S_MULW: begin
                o_cmd.mul_w = 1'b1;
                n_state     = S_SUMV;
            end
            S_SUMV: begin
                o_cmd.sum_v = 1'b1;
                n_state     = S_MULV;
            end
            S_MULV: begin
                o_cmd.mul_v = 1'b1;
                n_state     = S_FIN;
            end
            S_FIN: begin
                // hold until the output register is free
                if (!i_stat.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

/* src/rvb_dp.sv */
module rvb_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rvb_pkg::t_cmd    i_cmd,
    output rvb_pkg::t_stat   o_stat,
    input  rvb_pkg::t_cfg    i_cfg,
    input  rvb_pkg::t_sample i_sample_in,
    input  logic             i_sound_start,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output rvb_pkg::t_sample o_sample_out,
    output logic             o_clipped
);

    localparam int SB = rvb_pkg::SAMPLE_BITS;

    rvb_pkg::t_sample r_store [rvb_pkg::DELAY_DEPTH];

    logic [rvb_pkg::ADDR_W-1:0]  r_wp;
    logic [rvb_pkg::COUNT_W-1:0] r_count;
    rvb_pkg::t_sample            r_x;
    rvb_pkg::t_sample            r_rd_data;
    logic [rvb_pkg::TAP_IDX_W-1:0] r_mac_tap;
    logic                        r_mac_gate;
    logic                        r_mac_zero;

    logic signed [rvb_pkg::TSUM_W-1:0] r_tsum;
    logic signed [rvb_pkg::P_W-1:0]    r_prod;
    logic signed [rvb_pkg::B_W-1:0]    r_v;

    logic             r_out_valid;
    rvb_pkg::t_sample r_sample_out;
    logic             r_clipped;

    logic [rvb_pkg::DELAY_W-1:0] sel_delay;
    logic [rvb_pkg::ADDR_W-1:0]  rd_addr;
    logic                        tap_gate;
    logic                        tap_zero;
    rvb_pkg::t_sample            tap_val;

    logic signed [rvb_pkg::A_W-1:0] mul_a;
    logic signed [rvb_pkg::B_W-1:0] mul_b;
    logic signed [rvb_pkg::P_W-1:0] prod;

    logic signed [rvb_pkg::P_W-1:0] rnd_w;
    logic signed [rvb_pkg::P_W-1:0] tw_full;
    logic signed [rvb_pkg::B_W-1:0] x_b;
    logic signed [rvb_pkg::B_W-1:0] v;

    logic signed [rvb_pkg::P_W-1:0] rnd_y;
    logic signed [rvb_pkg::P_W-1:0] y_frac;
    logic signed [rvb_pkg::Y_W-1:0] y_full;
    rvb_pkg::t_sample               y_sat;
    logic                           y_clip;

    // Tap address and gating
    assign sel_delay = i_cfg.tap_delay[i_cmd.rd_tap];
    assign rd_addr   = r_wp - rvb_pkg::ADDR_W'(sel_delay);
    assign tap_gate  = (32'(sel_delay) < 32'(rvb_pkg::DELAY_DEPTH))
                    && (32'(r_count) >= 32'(sel_delay));
    assign tap_zero  = (sel_delay == '0);

    // Zero delay takes the sample written this item
    assign tap_val = r_mac_zero ? r_x : r_rd_data;

    // Shared multiplier
    always_comb begin
        if (i_cmd.mac_en) begin
            mul_a = {1'b0, rvb_pkg::decay_q16(r_mac_tap)};
            mul_b = {{(rvb_pkg::B_W-SB){tap_val[SB-1]}}, tap_val};
        end else if (i_cmd.mul_w) begin
            mul_a = {1'b0, i_cfg.wet_gain};
            mul_b = {{(rvb_pkg::B_W-rvb_pkg::TSUM_W){r_tsum[rvb_pkg::TSUM_W-1]}}, r_tsum};
        end else begin
            mul_a = {1'b0, i_cfg.wet_gain};
            mul_b = r_v;
        end
    end

    assign prod = mul_a * mul_b;

    // Wet term: tw rounded, then v = x*2^15 + tw
    assign rnd_w   = r_prod + rvb_pkg::RND_W;
    assign tw_full = rnd_w >>> rvb_pkg::GAIN_W;
    assign x_b     = {{(rvb_pkg::B_W-SB){r_x[SB-1]}}, r_x};
    assign v       = (x_b <<< (rvb_pkg::GAIN_W - 1)) + tw_full[rvb_pkg::B_W-1:0];

    // Final rounding and saturation
    assign rnd_y  = r_prod + rvb_pkg::RND_Y;
    assign y_frac = rnd_y >>> (2 * rvb_pkg::GAIN_W);
    assign y_full = {{(rvb_pkg::Y_W-SB){r_x[SB-1]}}, r_x} + y_frac[rvb_pkg::Y_W-1:0];

    always_comb begin
        y_clip = 1'b0;
        y_sat  = y_full[SB-1:0];
        if (y_full > rvb_pkg::SAT_HI) begin
            y_sat  = rvb_pkg::SAMPLE_MAX;
            y_clip = 1'b1;
        end else if (y_full < rvb_pkg::SAT_LO) begin
            y_sat  = rvb_pkg::SAMPLE_MIN;
            y_clip = 1'b1;
        end
    end

    // Delay memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_store[r_wp] <= i_sample_in;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_store[rd_addr];
        end
    end

    // Position and sound count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_count <= '0;
        end else if (i_cmd.accept) begin
            if (i_sound_start) begin
                r_count <= '0;
            end
        end else if (i_cmd.load_out) begin
            r_wp <= r_wp + rvb_pkg::ADDR_W'(1);
            if (r_count != rvb_pkg::COUNT_W'(rvb_pkg::COUNT_MAX)) begin
                r_count <= r_count + rvb_pkg::COUNT_W'(1);
            end
        end
    end

    // Arithmetic registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_x    <= i_sample_in;
            r_tsum <= '0;
        end
        if (i_cmd.rd_en) begin
            r_mac_tap  <= i_cmd.rd_tap;
            r_mac_gate <= tap_gate;
            r_mac_zero <= tap_zero;
        end
        if (i_cmd.mac_en && r_mac_gate) begin
            r_tsum <= r_tsum + prod[rvb_pkg::TSUM_W-1:0];
        end
        if (i_cmd.mul_w || i_cmd.mul_v) begin
            r_prod <= prod;
        end
        if (i_cmd.sum_v) begin
            r_v <= v;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_sample_out <= y_sat;
            r_clipped    <= y_clip;
        end
    end

    assign o_stat.out_busy = r_out_valid && i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_sample_out    = r_sample_out;
    assign o_clipped       = r_clipped;

endmodule

/* src/four_tap_delay_reverb_top.sv */
// Four-tap feed-forward delay reverb.
// Items are handled one at a time: the input stalls until the current result is loaded,
// as the four tap reads share the single read port of the delay memory and the wet-gain
// products share the one multiplier. A stalled output holds the result load and the input.
// Reset (synchronous, active low) clears the controller, write position, sound count and
// output valid, and returns the registers to defaults; the delay memory is not cleared.
module four_tap_delay_reverb_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  rvb_pkg::t_sample                 i_sample_in,
    input  logic                             i_sound_start,
    // output channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output rvb_pkg::t_sample                 o_sample_out,
    output logic                             o_clipped,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [rvb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rvb_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic [rvb_pkg::NUM_TAPS-1:0][rvb_pkg::DELAY_W-1:0] r_tap_delay;
    logic [rvb_pkg::GAIN_W-1:0]                         r_wet_gain;

    rvb_pkg::t_cfg  cfg;
    rvb_pkg::t_cmd  cmd;
    rvb_pkg::t_stat stat;

    // Configuration registers; writes to unknown indexes drop silently.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_delay[rvb_pkg::TAP_FIRST]  <= rvb_pkg::RST_TAP_FIRST;
            r_tap_delay[rvb_pkg::TAP_SECOND] <= rvb_pkg::RST_TAP_SECOND;
            r_tap_delay[rvb_pkg::TAP_THIRD]  <= rvb_pkg::RST_TAP_THIRD;
            r_tap_delay[rvb_pkg::TAP_FOURTH] <= rvb_pkg::RST_TAP_FOURTH;
            r_wet_gain                       <= rvb_pkg::RST_WET_GAIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rvb_pkg::CFG_TAP_FIRST:
                    r_tap_delay[rvb_pkg::TAP_FIRST] <= i_cfg_data[rvb_pkg::DELAY_W-1:0];
                rvb_pkg::CFG_TAP_SECOND:
                    r_tap_delay[rvb_pkg::TAP_SECOND] <= i_cfg_data[rvb_pkg::DELAY_W-1:0];
                rvb_pkg::CFG_TAP_THIRD:
                    r_tap_delay[rvb_pkg::TAP_THIRD] <= i_cfg_data[rvb_pkg::DELAY_W-1:0];
                rvb_pkg::CFG_TAP_FOURTH:
                    r_tap_delay[rvb_pkg::TAP_FOURTH] <= i_cfg_data[rvb_pkg::DELAY_W-1:0];
                rvb_pkg::CFG_WET_GAIN:
                    r_wet_gain <= i_cfg_data[rvb_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.tap_delay = r_tap_delay;
    assign cfg.wet_gain  = r_wet_gain;

    // Controller: sequences tap reads, accumulation, wet products and the result load.
    rvb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    // Datapath: delay memory, shared multiplier, rounding, saturation, output register.
    rvb_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg         (cfg),
        .i_sample_in   (i_sample_in),
        .i_sound_start (i_sound_start),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_sample_out  (o_sample_out),
        .o_clipped     (o_clipped)
    );

    // An accepted item blocks the input on the next cycle.
    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepting an item");

    // A clipped result sits at one of the rails.
    a_clip_at_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_clipped) |->
        (o_sample_out == rvb_pkg::SAMPLE_MAX || o_sample_out == rvb_pkg::SAMPLE_MIN))
        else $error("clipped result not at a saturation rail");

    // Reset leaves the block empty and ready.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("block not idle after reset");

endmodule
